[src/xtea_block_cipher_assert.svh]
// Assertion macros shared by the XTEA cipher checkers.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef XTEA_BLOCK_CIPHER_ASSERT_SVH
`define XTEA_BLOCK_CIPHER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define XTEA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset cycles included.
`define XTEA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[src/xtea_pkg.sv]
// Shared types, constants and round-key helpers for the XTEA block cipher.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package xtea_pkg;

    localparam int ROUND_COUNT = 32;
    localparam int HALF_COUNT  = 2 * ROUND_COUNT;
    localparam int KEY_COUNT   = 4;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam logic [31:0] DELTA_NEG = 32'h61C8_8647;

    typedef enum logic [1:0] {
        KEY_W0 = 2'd0,
        KEY_W1 = 2'd1,
        KEY_W2 = 2'd2,
        KEY_W3 = 2'd3
    } t_key_idx;

    typedef logic [31:0] t_rk_arr [HALF_COUNT];

    typedef struct packed {
        logic        enc;
        logic [31:0] v0;
        logic [31:0] v1;
        logic        last;
    } t_stage;

    typedef struct packed {
        logic [31:0] left;
        logic [31:0] right;
        logic        last;
    } t_result;

    function automatic logic [31:0] mix(input logic [31:0] v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

    // Round sum seen by encrypt half-round j: one delta per completed round,
    // and the odd half already sees the advanced sum.
    function automatic logic [31:0] half_sum(input int j);
        logic [31:0] rnd;
        rnd = 32'((j + 1) >> 1);
        return 32'd0 - rnd * DELTA_NEG;
    endfunction

    // Key word select: low sum bits on even halves, bits 12:11 on odd halves.
    function automatic logic [1:0] half_key_sel(input int j);
        logic [31:0] s;
        s = half_sum(j);
        return (j % 2 == 1) ? s[12:11] : s[1:0];
    endfunction

endpackage

`default_nettype wire

[src/xtea_key_sched.sv]
// Key registers behind the APB port and the registered per-half-round keys.
// Depends on xtea_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xtea_key_sched
    import xtea_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output t_rk_arr                o_rk
);

    logic [31:0] r_key [KEY_COUNT];
    logic [31:0] n_key [KEY_COUNT];
    logic [31:0] r_rk  [HALF_COUNT];
    logic        wr_en;
    t_key_idx    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_key_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEY_COUNT; k++) begin
                r_key[k] <= '0;
            end
        end else if (wr_en) begin
            case (reg_idx)
                KEY_W0:  r_key[0] <= pwdata;
                KEY_W1:  r_key[1] <= pwdata;
                KEY_W2:  r_key[2] <= pwdata;
                KEY_W3:  r_key[3] <= pwdata;
                default: r_key[0] <= r_key[0];
            endcase
        end
    end

    // Key words as they stand after this edge, write included.
    always_comb begin
        for (int k = 0; k < KEY_COUNT; k++) begin
            n_key[k] = r_key[k];
        end
        if (!i_rst_n) begin
            for (int k = 0; k < KEY_COUNT; k++) begin
                n_key[k] = '0;
            end
        end else if (wr_en) begin
            case (reg_idx)
                KEY_W0:  n_key[0] = pwdata;
                KEY_W1:  n_key[1] = pwdata;
                KEY_W2:  n_key[2] = pwdata;
                KEY_W3:  n_key[3] = pwdata;
                default: n_key[0] = r_key[0];
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            KEY_W0:  prdata = r_key[0];
            KEY_W1:  prdata = r_key[1];
            KEY_W2:  prdata = r_key[2];
            KEY_W3:  prdata = r_key[3];
            default: prdata = '0;
        endcase
    end

    // Each half-round key is a fixed sum constant plus one key word; build it
    // from the incoming key so a block taken right after a write sees the new key.
    for (genvar j = 0; j < HALF_COUNT; j++) begin : g_rk
        always_ff @(posedge i_clk) begin
            r_rk[j] <= half_sum(j) + n_key[half_key_sel(j)];
        end
        assign o_rk[j] = r_rk[j];
    end

endmodule

`default_nettype wire

[src/xtea_half_round.sv]
// One pipeline stage of the cipher: a single XTEA half-round for either direction.
// Depends on xtea_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xtea_half_round
    import xtea_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_adv,
    input  wire logic        i_valid,
    input  wire t_stage      i_data,
    input  wire logic [31:0] i_rk_enc,
    input  wire logic [31:0] i_rk_dec,
    input  wire logic        i_odd,
    output logic             o_valid,
    output t_stage           o_data
);

    logic        r_valid;
    t_stage      r_data;
    t_stage      n_data;
    logic        upd_v0;
    logic [31:0] a_word;
    logic [31:0] b_word;
    logic [31:0] f_word;
    logic [31:0] a_next;

    // Encrypt updates v0 on even halves; decrypt runs the schedule backward.
    assign upd_v0 = i_data.enc ^ i_odd;

    always_comb begin
        a_word = upd_v0 ? i_data.v0 : i_data.v1;
        b_word = upd_v0 ? i_data.v1 : i_data.v0;
        f_word = mix(b_word) ^ (i_data.enc ? i_rk_enc : i_rk_dec);
        a_next = i_data.enc ? (a_word + f_word) : (a_word - f_word);
        n_data = i_data;
        if (upd_v0) begin
            n_data.v0 = a_next;
        end else begin
            n_data.v1 = a_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

[src/xtea_out_buf.sv]
// Output register with a skid stage; decouples the pipeline from the sink.
// Depends on xtea_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xtea_out_buf
    import xtea_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_result i_data,
    output logic         o_adv,
    output logic         o_valid,
    output t_result      o_data,
    input  wire logic    i_ready
);

    logic    r_out_v;
    logic    r_skid_v;
    t_result r_out;
    t_result r_skid;
    logic    load_out;
    logic    load_skid;
    logic    drain_skid;

    assign o_adv      = !r_skid_v;
    assign load_out   = !r_skid_v && (!r_out_v || i_ready);
    assign load_skid  = !r_skid_v && r_out_v && !i_ready && i_valid;
    assign drain_skid = r_skid_v && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_v <= i_valid;
            end
            if (load_skid) begin
                r_skid_v <= 1'b1;
            end else if (drain_skid) begin
                r_skid_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= i_data;
        end else if (drain_skid) begin
            r_out <= r_skid;
        end
        if (load_skid) begin
            r_skid <= i_data;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

`default_nettype wire

[src/xtea_block_cipher.sv]
// Top level of the pipelined XTEA block cipher.
// Depends on xtea_pkg, xtea_key_sched, xtea_half_round and xtea_out_buf.
`timescale 1ns / 1ps
`default_nettype none

// XTEA (64-bit block, 128-bit key, ROUND_COUNT rounds) in ECB fashion. The key
// sits in four APB registers at byte addresses 0x0, 0x4, 0x8 and 0xC; write them
// while no block is in flight; a block may enter in the cycle after the write.
// Each block carries its own direction (req_type 1 encrypts, 0 decrypts) and a
// last mark that comes out unchanged. The datapath is a chain of 2*ROUND_COUNT
// half-round stages, one register each, followed by an output register. A new
// block can be taken every cycle as long as the skid stage is empty: a skid
// stage behind the output register lets one more block move up while a result
// waits; after that the whole chain holds until the sink takes a transfer.
module xtea_block_cipher
    import xtea_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_req_type,
    input  wire logic [31:0]       i_block_left,
    input  wire logic [31:0]       i_block_right,
    input  wire logic              i_block_last,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic      [31:0]       o_result_left,
    output logic      [31:0]       o_result_right,
    output logic                   o_result_last
);

    t_rk_arr rk;
    logic    adv;
    logic    stg_valid [HALF_COUNT+1];
    t_stage  stg_data  [HALF_COUNT+1];
    t_result res_in;
    t_result res_out;

    xtea_key_sched u_key_sched (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_rk    (rk)
    );

    assign o_in_ready   = adv;
    assign stg_valid[0] = i_in_valid;
    assign stg_data[0]  = '{enc: i_req_type, v0: i_block_left, v1: i_block_right,
                            last: i_block_last};

    for (genvar j = 0; j < HALF_COUNT; j++) begin : g_stage
        xtea_half_round u_half_round (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (adv),
            .i_valid  (stg_valid[j]),
            .i_data   (stg_data[j]),
            .i_rk_enc (rk[j]),
            .i_rk_dec (rk[HALF_COUNT-1-j]),
            .i_odd    ((j % 2) == 1),
            .o_valid  (stg_valid[j+1]),
            .o_data   (stg_data[j+1])
        );
    end

    assign res_in = '{left: stg_data[HALF_COUNT].v0, right: stg_data[HALF_COUNT].v1,
                      last: stg_data[HALF_COUNT].last};

    xtea_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stg_valid[HALF_COUNT]),
        .i_data  (res_in),
        .o_adv   (adv),
        .o_valid (o_out_valid),
        .o_data  (res_out),
        .i_ready (i_out_ready)
    );

    assign o_result_left  = res_out.left;
    assign o_result_right = res_out.right;
    assign o_result_last  = res_out.last;

endmodule

`default_nettype wire

[src/xtea_block_cipher_chk.sv]
// Port-level checker for the XTEA cipher, bound to the top level.
// Depends on xtea_pkg and xtea_block_cipher_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "xtea_block_cipher_assert.svh"

module xtea_block_cipher_chk
    import xtea_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    input  wire logic [DATA_W-1:0] prdata,
    input  wire logic              pready,
    input  wire logic              i_in_valid,
    input  wire logic              o_in_ready,
    input  wire logic              i_req_type,
    input  wire logic [31:0]       i_block_left,
    input  wire logic [31:0]       i_block_right,
    input  wire logic              i_block_last,
    input  wire logic              o_out_valid,
    input  wire logic              i_out_ready,
    input  wire logic [31:0]       o_result_left,
    input  wire logic [31:0]       o_result_right,
    input  wire logic              o_result_last
);

    // A result offered and not taken stays put.
    `XTEA_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result_left) && $stable(o_result_right) && $stable(o_result_last), "result changed while stalled")

    // The input side only backs up once a result is waiting.
    `XTEA_ASSERT(a_stall_cause, !o_in_ready |-> o_out_valid, "input stalled with no result pending")

    // Reset empties the output.
    `XTEA_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid, "result valid right after reset")

    // A key read right after its write returns the written word.
    `XTEA_ASSERT(a_key_readback, (psel && penable && pwrite && pready) ##1 (psel && !pwrite && paddr == $past(paddr)) |-> prdata == $past(pwdata), "key readback mismatch")

endmodule

bind xtea_block_cipher xtea_block_cipher_chk u_chk (.*);

`default_nettype wire

[tb/xtea_result_checker.sv]
// Checker for the XTEA block cipher: watches the APB port and both block channels,
// predicts each cipher result from its own copy of the key, and compares.
// Depends on xtea_pkg for widths, the round count and the result type.
`timescale 1ns / 1ps

module xtea_result_checker
    import xtea_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic [DATA_W-1:0] prdata,
    input  logic              pready,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic              i_req_type,
    input  logic [31:0]       i_block_left,
    input  logic [31:0]       i_block_right,
    input  logic              i_block_last,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [31:0]       i_result_left,
    input  logic [31:0]       i_result_right,
    input  logic              i_result_last,
    output int                o_fail_count,
    output int                o_checked,
    output int                o_pending
);

    logic [KEY_COUNT-1:0][31:0] key_copy;
    t_result                    expected_blocks [$];
    t_result                    oldest;
    int                         fail_count = 0;
    int                         reg_idx;

    assign o_fail_count = fail_count;

    function automatic logic [31:0] feistel_mix(input logic [31:0] v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

    function automatic t_result xtea_cipher_block(input logic enc, input logic [31:0] left,
                                                  input logic [31:0] right, input logic last);
        logic [31:0] v0;
        logic [31:0] v1;
        logic [31:0] sum;
        t_result     res;
        v0 = left;
        v1 = right;
        if (enc) begin
            sum = 32'd0;
            for (int r = 0; r < ROUND_COUNT; r++) begin
                v0 += feistel_mix(v1) ^ (sum + key_copy[sum[1:0]]);
                sum -= DELTA_NEG;
                v1 += feistel_mix(v0) ^ (sum + key_copy[sum[12:11]]);
            end
        end else begin
            // start from the sum the encrypt side ends on
            sum = 32'd0 - 32'(ROUND_COUNT) * DELTA_NEG;
            for (int r = 0; r < ROUND_COUNT; r++) begin
                v1 -= feistel_mix(v0) ^ (sum + key_copy[sum[12:11]]);
                sum += DELTA_NEG;
                v0 -= feistel_mix(v1) ^ (sum + key_copy[sum[1:0]]);
            end
        end
        res.left  = v0;
        res.right = v1;
        res.last  = last;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_copy  <= '0;
            o_checked <= 0;
            o_pending <= 0;
        end else begin
            if (psel && penable && pready) begin
                reg_idx = int'(paddr >> 2);
                if (pwrite) begin
                    if (reg_idx < KEY_COUNT) begin
                        key_copy[reg_idx] <= pwdata;
                    end
                end else if (reg_idx < KEY_COUNT && prdata !== key_copy[reg_idx]) begin
                    report_mismatch("key readback", prdata, key_copy[reg_idx]);
                end
            end
            // pop before push so an early result never meets its own block
            if (i_out_valid && i_out_ready) begin
                o_checked <= o_checked + 1;
                if (expected_blocks.size() == 0) begin
                    report_mismatch("result with no block pending", i_result_left, 32'd0);
                end else begin
                    oldest = expected_blocks.pop_front();
                    if (i_result_left !== oldest.left)
                        report_mismatch("result_left", i_result_left, oldest.left);
                    if (i_result_right !== oldest.right)
                        report_mismatch("result_right", i_result_right, oldest.right);
                    if (i_result_last !== oldest.last)
                        report_mismatch("result_last", 32'(i_result_last), 32'(oldest.last));
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_blocks.push_back(xtea_cipher_block(i_req_type, i_block_left,
                                                            i_block_right, i_block_last));
            end
            o_pending <= expected_blocks.size();
        end
    end

endmodule

[tb/tb_xtea_block_cipher.sv]
// Testbench top for the XTEA block cipher: drives key writes over APB and blocks
// with random idling on both channels; the checker module judges every result.
// Depends on xtea_pkg, xtea_block_cipher and xtea_result_checker.
`timescale 1ns / 1ps

module tb_xtea_block_cipher
    import xtea_pkg::*;
;

    localparam int CYCLE_LIMIT = 800_000;
    localparam int PHASE_ITEMS = 290;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic              i_req_type = 1'b0;
    logic [31:0]       i_block_left = '0;
    logic [31:0]       i_block_right = '0;
    logic              i_block_last = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [31:0]       o_result_left;
    logic [31:0]       o_result_right;
    logic              o_result_last;

    int   fail_count;
    int   checked_count;
    int   pending_count;
    int   sent_count = 0;
    int   cycle_count = 0;
    int   stall_left = 0;
    logic tx_idle_en = 1'b1;
    logic rx_idle_en = 1'b1;

    xtea_block_cipher dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_block_left   (i_block_left),
        .i_block_right  (i_block_right),
        .i_block_last   (i_block_last),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_left  (o_result_left),
        .o_result_right (o_result_right),
        .o_result_last  (o_result_last)
    );

    xtea_result_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_block_left   (i_block_left),
        .i_block_right  (i_block_right),
        .i_block_last   (i_block_last),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_result_left  (o_result_left),
        .i_result_right (o_result_right),
        .i_result_last  (o_result_last),
        .o_fail_count   (fail_count),
        .o_checked      (checked_count),
        .o_pending      (pending_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Sink side: drop ready in random bursts while idling is allowed; else hold it high.
    always @(posedge i_clk) begin
        if (!rx_idle_en) begin
            stall_left = 0;
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Setup cycle then access cycle; psel stays up so transfers can run back to back.
    task automatic apb_transfer(input logic write, input t_key_idx idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    task automatic write_key_set(input logic [31:0] k0, input logic [31:0] k1,
                                 input logic [31:0] k2, input logic [31:0] k3);
        apb_transfer(1'b1, KEY_W0, k0);
        apb_transfer(1'b1, KEY_W1, k1);
        apb_transfer(1'b1, KEY_W2, k2);
        apb_transfer(1'b1, KEY_W3, k3);
        apb_transfer(1'b0, KEY_W0, 32'd0);
        apb_transfer(1'b0, KEY_W1, 32'd0);
        apb_transfer(1'b0, KEY_W2, 32'd0);
        apb_transfer(1'b0, KEY_W3, 32'd0);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_block(input logic enc, input logic [31:0] left,
                              input logic [31:0] right, input logic last);
        if (tx_idle_en && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_req_type    <= enc;
        i_block_left  <= left;
        i_block_right <= right;
        i_block_last  <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent_count++;
    endtask

    // Drop valid and hold until every block sent so far has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (checked_count < sent_count) @(posedge i_clk);
    endtask

    task automatic run_directed();
        logic [31:0] lefts  [6];
        logic [31:0] rights [6];
        lefts  = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                   32'hFFFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA};
        rights = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'h0000_0000, 32'h0000_0001, 32'h5555_5555};
        for (int i = 0; i < 6; i++) begin
            for (int e = 0; e < 2; e++) begin
                send_block(e[0], lefts[i], rights[i], e[0] ^ i[0]);
            end
        end
        drain_results();
    endtask

    function automatic logic [31:0] pick_word();
        logic [31:0] corners [5];
        corners = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF};
        if ($urandom_range(0, 7) == 0) return corners[$urandom_range(0, 4)];
        return $urandom;
    endfunction

    // Random messages of 1 to 8 blocks, the final one marked last.
    task automatic run_random(input int count, input logic idle_allowed);
        int msg_left;
        msg_left = 0;
        for (int n = 0; n < count; n++) begin
            if (msg_left == 0) msg_left = $urandom_range(1, 8);
            msg_left--;
            tx_idle_en = idle_allowed && ((n % 120) < 80);
            rx_idle_en <= idle_allowed && (((n + 40) % 120) < 80);
            send_block(1'($urandom_range(0, 1)), pick_word(), pick_word(), msg_left == 0);
        end
        drain_results();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset key first, then the all-ones key
        run_directed();
        write_key_set(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_directed();

        write_key_set(32'h0001_0203, 32'h0405_0607, 32'h0809_0A0B, 32'h0C0D_0E0F);
        run_random(PHASE_ITEMS, 1'b1);
        write_key_set($urandom, $urandom, $urandom, $urandom);
        run_random(PHASE_ITEMS, 1'b1);
        write_key_set(32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        run_random(PHASE_ITEMS, 1'b1);
        write_key_set($urandom, $urandom, $urandom, $urandom);
        run_random(PHASE_ITEMS, 1'b1);
        write_key_set(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        run_random(PHASE_ITEMS, 1'b1);
        write_key_set($urandom, $urandom, $urandom, $urandom);
        run_random(PHASE_ITEMS, 1'b0);

        // let the pipeline settle before the verdict
        repeat (3 * HALF_COUNT) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
